// ===== sv/sstf_disk_scheduler_macros.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef SSTF_DISK_SCHEDULER_MACROS_SVH
`define SSTF_DISK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSTF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sstf checker: same-cycle rule failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sstf checker: next-cycle rule failed");

`endif

// ===== sv/sstf_pkg.sv =====
// Package: word types and defaults for the SSTF disk scheduler.
`timescale 1ns / 1ps
`default_nettype none
package sstf_pkg;

  localparam int QueueDepthDef = 64;
  localparam int TrackBitsDef  = 16;

  localparam int SeekW  = 16;
  localparam int TotalW = 22;

  localparam logic [SeekW-1:0]  SeekMax  = 16'hFFFF;
  localparam logic [TotalW-1:0] TotalMax = 22'h3FFFFF;

  // Command codes of an input word
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] track;
  } sstf_in_t;

  typedef struct packed {
    logic [15:0]       served_track;
    logic [SeekW-1:0]  seek_len;
    logic [TotalW-1:0] total_distance;
    logic              last;
  } sstf_out_t;

endpackage
`default_nettype wire

// ===== sv/sstf_track_mem.sv =====
// Request track table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sstf_track_mem #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/sstf_dist_unit.sv =====
// Shared distance unit: |candidate - head| and compare against the best so far.
`timescale 1ns / 1ps
`default_nettype none
module sstf_dist_unit #(
  parameter int TRACK_BITS = 16
) (
  input  wire logic [TRACK_BITS-1:0] cand,
  input  wire logic [TRACK_BITS-1:0] head,
  input  wire logic [TRACK_BITS-1:0] best,
  input  wire logic                  found,
  output logic      [TRACK_BITS-1:0] span,
  output logic                       take
);

  // Absolute difference
  always_comb begin
    if (cand >= head) begin
      span = cand - head;
    end else begin
      span = head - cand;
    end
  end

  // Strictly nearer wins, so the earliest entry keeps a tie
  assign take = !found || (span < best);

endmodule
`default_nettype wire

// ===== sv/sstf_disk_scheduler.sv =====
// Top level: shortest-seek-time-first scheduler with table, sequencer and distance unit.
//
// Usage:
//   Input words (in_item) are taken when start is high and busy is low.
//   A load word (cmd 0) stores one request track; loads may
//   follow back to back. A load on a full table is dropped.
//   A run word (cmd 1) carries the start head track. With n requests stored
//   the block serves them in nearest-first order, one result word per step
//   on out_item, shown for one cycle with out_strobe. Each step scans the
//   table through the one memory read port and the shared distance unit.
//   busy stays high for the whole run; the last word carries last = 1 and
//   shows in the same cycle that busy drops. A run on an empty table
//   gives no word and leaves busy low. After a run the table is empty.
//   The receiver cannot stall; every strobed word must be taken.
//   Reset (rst_n low, synchronous) empties the table and clears all served
//   marks at once; the stored track values themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sstf_disk_scheduler
  import sstf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int TRACK_BITS  = TrackBitsDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire sstf_in_t  in_item,
  output logic           busy,
  output logic           out_strobe,
  output sstf_out_t      out_item
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((TRACK_BITS > TotalW) ? TRACK_BITS : TotalW) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Control registers
  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]       step_r, step_nxt;
  logic                   pv_r, pv_nxt;
  logic                   found_r, found_nxt;
  logic [QUEUE_DEPTH-1:0] served_r, served_nxt;
  logic                   out_strobe_r, out_strobe_nxt;

  // Payload registers
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic [TRACK_BITS-1:0]  head_r, head_nxt;
  logic [TRACK_BITS-1:0]  best_r, best_nxt;
  logic [TRACK_BITS-1:0]  best_trk_r, best_trk_nxt;
  logic [TotalW-1:0]      total_r, total_nxt;
  sstf_out_t              out_r, out_nxt;

  // Memory and distance unit wiring
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [TRACK_BITS-1:0]  in_trk;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [TRACK_BITS-1:0]  rd_data;
  logic [TRACK_BITS-1:0]  span;
  logic                   take;

  logic                   accept;
  logic                   scan_done;
  logic                   is_last;
  logic [SUM_W-1:0]       best_w;
  logic [SUM_W-1:0]       sum_w;
  logic [SeekW-1:0]       seek_sat;
  logic [TotalW-1:0]      total_sat;

  assign in_trk  = TRACK_BITS'(in_item.track);
  assign accept  = start && (state_r == ST_IDLE);
  assign wr_en   = accept && (in_item.cmd == CMD_LOAD) && (count_r < CNT_W'(QUEUE_DEPTH));
  assign wr_addr = count_r[IDX_W-1:0];
  assign rd_en   = (state_r == ST_SCAN) && (rd_idx_r < count_r);
  assign rd_addr = rd_idx_r[IDX_W-1:0];

  sstf_track_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .WIDTH  (TRACK_BITS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_trk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  sstf_dist_unit #(
    .TRACK_BITS (TRACK_BITS)
  ) u_dist (
    .cand  (rd_data),
    .head  (head_r),
    .best  (best_r),
    .found (found_r),
    .span  (span),
    .take  (take)
  );

  // Saturate the chosen distance and the running total
  assign best_w    = SUM_W'(best_r);
  assign sum_w     = SUM_W'(total_r) + best_w;
  assign seek_sat  = (best_w > SUM_W'(SeekMax)) ? SeekMax : best_w[SeekW-1:0];
  assign total_sat = (sum_w > SUM_W'(TotalMax)) ? TotalMax : sum_w[TotalW-1:0];
  assign scan_done = pv_r && ((CNT_W'(pidx_r) + CNT_W'(1)) == count_r);
  assign is_last   = (step_r + CNT_W'(1)) == count_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    step_nxt       = step_r;
    pv_nxt         = 1'b0;
    found_nxt      = found_r;
    served_nxt     = served_r;
    out_strobe_nxt = 1'b0;
    pidx_nxt       = pidx_r;
    pick_nxt       = pick_r;
    head_nxt       = head_r;
    best_nxt       = best_r;
    best_trk_nxt   = best_trk_r;
    total_nxt      = total_r;
    out_nxt        = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_LOAD) begin
            if (wr_en) begin
              served_nxt[wr_addr] = 1'b0;
              count_nxt           = count_r + CNT_W'(1);
            end
          end else if (count_r != '0) begin
            head_nxt   = in_trk;
            total_nxt  = '0;
            step_nxt   = '0;
            rd_idx_nxt = '0;
            found_nxt  = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next table read
        if (rd_en) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_addr;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        // Compare the entry read last cycle
        if (pv_r && !served_r[pidx_r] && take) begin
          found_nxt    = 1'b1;
          best_nxt     = span;
          best_trk_nxt = rd_data;
          pick_nxt     = pidx_r;
        end
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Serve the pick and move the head
        out_strobe_nxt         = 1'b1;
        out_nxt.served_track   = 16'(best_trk_r);
        out_nxt.seek_len       = seek_sat;
        out_nxt.total_distance = total_sat;
        out_nxt.last           = is_last;
        total_nxt              = total_sat;
        head_nxt               = best_trk_r;
        served_nxt[pick_r]     = 1'b1;
        step_nxt               = step_r + CNT_W'(1);
        rd_idx_nxt             = '0;
        found_nxt              = 1'b0;
        if (is_last) begin
          count_nxt  = '0;
          served_nxt = '0;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rd_idx_r     <= '0;
      step_r       <= '0;
      pv_r         <= 1'b0;
      found_r      <= 1'b0;
      served_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      step_r       <= step_nxt;
      pv_r         <= pv_nxt;
      found_r      <= found_nxt;
      served_r     <= served_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    pick_r     <= pick_nxt;
    head_r     <= head_nxt;
    best_r     <= best_nxt;
    best_trk_r <= best_trk_nxt;
    total_r    <= total_nxt;
    out_r      <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire

// ===== sv/sstf_checker.sv =====
// Port checker for the SSTF disk scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sstf_disk_scheduler_macros.svh"
module sstf_port_checker
  import sstf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire sstf_in_t  in_item,
  input wire logic      busy,
  input wire logic      out_strobe,
  input wire sstf_out_t out_item
);

  logic load_acc;
  logic run_acc;

  assign load_acc = start && !busy && (in_item.cmd == CMD_LOAD);
  assign run_acc  = start && !busy && (in_item.cmd == CMD_RUN);

  // A load never produces a word
  `SSTF_ASSERT_NEXT(a_load_no_word, load_acc, !out_strobe)
  // A run needs at least one full scan before its first word
  `SSTF_ASSERT_NEXT(a_run_no_early_word, run_acc, !out_strobe)
  // Words of one run never come in adjacent cycles
  `SSTF_ASSERT_NEXT(a_word_spacing, out_strobe, !out_strobe)
  // Only the last word of a run may show while idle
  `SSTF_ASSERT_SAME(a_mid_run_busy, out_strobe && !out_item.last, busy)

endmodule

bind sstf_disk_scheduler sstf_port_checker u_sstf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .in_item    (in_item),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire
